// ===== rtl/bhrs_pkg.sv =====
// ----------------------------------------------------------------------------
// bhrs_pkg: shared types and codes for the hint range search block
// command and result words, opcode and mode codes, sequencer states
// ----------------------------------------------------------------------------
package bhrs_pkg;

	localparam int KEY_W   = 32;
	localparam int SLOT_W  = 12;
	localparam int IDX_W   = 4;
	localparam int MODE_W  = 2;

	// opcodes
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	// hint modes
	localparam logic [MODE_W-1:0] MODE_OFF    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SCALAR = 2'd1;
	localparam logic [MODE_W-1:0] MODE_VECTOR = 2'd2;

	typedef struct packed {
		logic              opcode;
		logic [IDX_W-1:0]  hint_index;
		logic [KEY_W-1:0]  hint_value;
		logic [KEY_W-1:0]  key_head;
		logic [SLOT_W-1:0] slot_count;
		logic [SLOT_W-1:0] lower_in;
		logic [SLOT_W-1:0] upper_in;
	} cmd_t;

	typedef struct packed {
		logic [SLOT_W-1:0] lower_out;
		logic [SLOT_W-1:0] upper_out;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MUL_LO,
		ST_MUL_UP
	} state_t;

endpackage

// ===== rtl/bhrs_hint_store.sv =====
// ----------------------------------------------------------------------------
// bhrs_hint_store: hint word storage
// one write port, one registered read port, per-entry valid bits so that
// entries never written read as zero after reset
// ----------------------------------------------------------------------------
module bhrs_hint_store #(
	parameter int DEPTH  = 16,
	parameter int ADDR_W = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [ADDR_W-1:0]         wr_addr,
	input  logic [bhrs_pkg::KEY_W-1:0] wr_data,
	input  logic                      rd_en,
	input  logic [ADDR_W-1:0]         rd_addr,
	output logic [bhrs_pkg::KEY_W-1:0] rd_data
);
	import bhrs_pkg::*;

	logic [KEY_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [KEY_W-1:0] rd_raw_q;
	logic             rd_ok_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_raw_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_ok_q <= valid_q[rd_addr];
			end
		end
	end

	// unwritten entries hold the reset value of zero
	assign rd_data = rd_ok_q ? rd_raw_q : '0;

endmodule

// ===== rtl/btree_hint_range_search.sv =====
// ----------------------------------------------------------------------------
// btree_hint_range_search: narrows a B-tree node's slot range with hint words
// a table of sampled key heads is scanned by one shared comparator to turn a
// key head into narrowed lower and upper slot bounds
// ----------------------------------------------------------------------------
// A write word (opcode 0) stores one hint; busy stays low and no result
// comes out. A search word (opcode 1) always produces one result on the
// result port, marked by done for exactly one cycle; the receiver cannot
// stall, so capture it when done is high. A search that bypasses the hints
// (mode off or unlisted, or slot_count <= 2*HINT_COUNT) answers in the
// cycle after it is taken and leaves busy low. A narrowing search holds busy
// while the shared comparator visits k hint entries (k from 1 to
// HINT_COUNT), one per cycle through the table's read port, until the first
// entry differing from the key after the first one not below it; states
// ST_MUL_LO and ST_MUL_UP then run the bound products on one shared
// multiplier. The table reads as all zeros after reset with no clearing
// pass. hint_mode must be written through cfg_we / cfg_data only while busy
// is low; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module btree_hint_range_search #(
	parameter int HINT_COUNT = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  bhrs_pkg::cmd_t                cmd,
	input  logic                          cfg_we,
	input  logic [bhrs_pkg::MODE_W-1:0]   cfg_data,
	output logic                          done,
	output bhrs_pkg::rsp_t                result
);
	import bhrs_pkg::*;

	// table addressing and scan position widths
	localparam int HIDX_W = (HINT_COUNT > 1) ? $clog2(HINT_COUNT) : 1;
	localparam int POS_W  = $clog2(HINT_COUNT + 1);

	// dist = count / (HINT_COUNT+1) by reciprocal multiply plus one correction
	localparam int          DIV_D      = HINT_COUNT + 1;
	localparam int          RECIP_SH   = 24;
	localparam logic [23:0] RECIP      = 24'((1 << RECIP_SH) / DIV_D);
	localparam int          PROD_W     = SLOT_W + RECIP_SH;
	localparam int          REM_W      = SLOT_W + 8;
	localparam int          MUL_W      = POS_W + SLOT_W;

	localparam logic [POS_W-1:0] POS_END  = POS_W'(HINT_COUNT);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(HINT_COUNT - 1);

	// sequencer
	state_t state_q, state_d;

	// configuration
	logic [MODE_W-1:0] hint_mode_q;

	// captured search operands
	logic [KEY_W-1:0]  key_q;
	logic [SLOT_W-1:0] count_q;
	logic [SLOT_W-1:0] lower_in_q;
	logic [SLOT_W-1:0] upper_in_q;

	// scan state
	logic [POS_W-1:0]  scan_q;     // next table address to read
	logic [POS_W-1:0]  cmp_q;      // entry on the read data this cycle
	logic              phase_q;    // 0: looking for pos, 1: looking for pos2
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  pos2_q;

	// divider pipeline
	logic [PROD_W-1:0] prod_q;
	logic [SLOT_W-1:0] dist_q;
	logic [SLOT_W-1:0] q_est;
	logic [REM_W-1:0]  rem;

	// result register
	rsp_t result_q;
	logic done_q;

	// handshake and decode
	logic accept;
	logic is_search;
	logic bypass;
	logic wr_ok;

	// shared comparator
	logic [KEY_W-1:0] hint_rd;
	logic             hint_lt;
	logic             hint_eq;
	logic             scan_hit;    // scan decided pos2 on this entry
	logic             scan_end;

	// shared multiplier
	logic [POS_W-1:0] mul_a;
	logic [MUL_W-1:0] mul_p;
	logic             no_hit_keep;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign is_search = (cmd.opcode == OP_SEARCH);
	assign bypass    = ((hint_mode_q != MODE_SCALAR) && (hint_mode_q != MODE_VECTOR))
	                   || ({1'b0, cmd.slot_count} <= (SLOT_W + 1)'(2 * HINT_COUNT));
	assign wr_ok     = accept && !is_search && (int'(cmd.hint_index) < HINT_COUNT);

	// hint table
	bhrs_hint_store #(
		.DEPTH  (HINT_COUNT),
		.ADDR_W (HIDX_W)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_ok),
		.wr_addr (HIDX_W'(cmd.hint_index)),
		.wr_data (cmd.hint_value),
		.rd_en   (scan_q < POS_END),
		.rd_addr (HIDX_W'(scan_q)),
		.rd_data (hint_rd)
	);

	// one compare per cycle against the captured key
	assign hint_lt  = (hint_rd < key_q);
	assign hint_eq  = (hint_rd == key_q);
	assign scan_hit = phase_q ? !hint_eq : (!hint_lt && !hint_eq);
	assign scan_end = scan_hit || (cmp_q == POS_LAST);

	// constant divide: estimate then one correction step
	assign q_est = prod_q[PROD_W-1 -: SLOT_W];
	assign rem   = REM_W'(count_q) - REM_W'(q_est * DIV_D);

	// vector mode with no hint at or above the key keeps both bounds
	assign no_hit_keep = (hint_mode_q == MODE_VECTOR) && (pos_q == POS_END);

	// bound products share one multiplier
	assign mul_a = (state_q == ST_MUL_LO) ? pos_q : (pos2_q + POS_W'(1));
	assign mul_p = MUL_W'(mul_a) * MUL_W'(dist_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && is_search && !bypass) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_d = ST_MUL_LO;
				end
			end
			ST_MUL_LO: state_d = ST_MUL_UP;
			ST_MUL_UP: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hint_mode_q <= MODE_SCALAR;
			done_q      <= 1'b0;
			scan_q      <= '0;
			cmp_q       <= '0;
			phase_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				hint_mode_q <= cfg_data;
			end
			done_q <= (accept && is_search && bypass) || (state_q == ST_MUL_UP);
			case (state_q)
				ST_IDLE: begin
					phase_q <= 1'b0;
					cmp_q   <= '0;
					// entry 0 is read during idle, so the scan starts on it
					scan_q  <= (accept && is_search && !bypass) ? POS_W'(1) : '0;
				end
				ST_SCAN: begin
					scan_q <= scan_end ? '0 : scan_q + POS_W'(1);
					cmp_q  <= cmp_q + POS_W'(1);
					if (!phase_q && !hint_lt && hint_eq) begin
						phase_q <= 1'b1;
					end
				end
				default: begin
					scan_q <= '0;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		dist_q <= (rem >= REM_W'(DIV_D)) ? q_est + SLOT_W'(1) : q_est;
		if (accept && is_search) begin
			key_q      <= cmd.key_head;
			count_q    <= cmd.slot_count;
			lower_in_q <= cmd.lower_in;
			upper_in_q <= cmd.upper_in;
			prod_q     <= PROD_W'(cmd.slot_count) * PROD_W'(RECIP);
			pos_q      <= POS_END;
			pos2_q     <= POS_END;
			if (bypass) begin
				result_q.lower_out <= cmd.lower_in;
				result_q.upper_out <= cmd.upper_in;
			end
		end
		if (state_q == ST_SCAN) begin
			if (!phase_q && !hint_lt) begin
				pos_q <= cmp_q;
			end
			if (scan_hit) begin
				pos2_q <= cmp_q;
			end
		end
		if (state_q == ST_MUL_LO) begin
			result_q.lower_out <= no_hit_keep ? lower_in_q : mul_p[SLOT_W-1:0];
		end
		if (state_q == ST_MUL_UP) begin
			result_q.upper_out <= (pos2_q < POS_END) ? mul_p[SLOT_W-1:0] : upper_in_q;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// a result only appears once the sequencer is back in idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while sequencer busy");

	// a hint write never produces a result
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd.opcode == OP_WRITE)) |=> !done)
		else $error("result after a hint write");

	// the scan never runs past the last entry
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (cmp_q < POS_END))
		else $error("scan index beyond table");

	// the end of a run of equal hints never precedes the first hit
	a_pos_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL_LO) |-> (pos2_q >= pos_q))
		else $error("pos2 below pos");

	// the product pair always ends in exactly one result
	a_mul_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL_UP) |=> done)
		else $error("narrowing search gave no result");

endmodule

// ===== tb/btree_hint_range_search_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btree_hint_range_search_tb: self-checking bench for the hint range search
// drives write and search words through start/busy, predicts every search's
// bounds from a local copy of the hint table and mode, and checks each done
// word against the oldest pending prediction
// ----------------------------------------------------------------------------
module btree_hint_range_search_tb;

	import bhrs_pkg::*;

	localparam int HINTS    = 16;
	localparam int SETTLE   = HINTS + 4;     // worst-case search latency plus margin
	localparam int WATCHDOG = 2000;          // cycles with no word moving either way

	// mode 3 has no meaning in the block, it must behave like hints off
	localparam logic [MODE_W-1:0] MODE_UNLISTED = 2'd3;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	cmd_t              cmd;
	logic              cfg_we;
	logic [MODE_W-1:0] cfg_data;
	logic              done;
	rsp_t              result;

	btree_hint_range_search #(
		.HINT_COUNT(HINTS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data),
		.done    (done),
		.result  (result)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------------
	// bound predictor: private copy of the hint table and the mode register
	// ------------------------------------------------------------------------
	logic [KEY_W-1:0]  hint_tbl [HINTS];
	logic [MODE_W-1:0] mode_q;
	rsp_t              bound_q [$];        // predicted bounds, oldest first

	int err_cnt;
	int write_cnt;
	int search_cnt;
	int narrow_cnt;
	int checked_cnt;
	int stall_ctr;
	bit idle_on;

	// bounds a search word should come back with, given the current table and mode
	function automatic rsp_t predict_bounds(cmd_t c);
		rsp_t        r;
		int unsigned step;
		int unsigned first_ge;
		int unsigned first_ne;
		r.lower_out = c.lower_in;
		r.upper_out = c.upper_in;
		// small nodes are not worth narrowing
		if (c.slot_count <= 2 * HINTS)
			return r;
		if (mode_q != MODE_SCALAR && mode_q != MODE_VECTOR)
			return r;
		step = c.slot_count / (HINTS + 1);
		first_ge = 0;
		while (first_ge < HINTS && hint_tbl[first_ge] < c.key_head)
			first_ge++;
		// vector mode keeps both bounds when every hint is below the key
		if (mode_q == MODE_VECTOR && first_ge >= HINTS)
			return r;
		first_ne = first_ge;
		while (first_ne < HINTS && hint_tbl[first_ne] == c.key_head)
			first_ne++;
		narrow_cnt++;
		r.lower_out = SLOT_W'(first_ge * step);
		// a run of hints equal to the key up to the end leaves upper alone
		if (first_ne < HINTS)
			r.upper_out = SLOT_W'((first_ne + 1) * step);
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// monitor: sample at the rising edge, results checked before new words
	// are taken so a word accepted now can never match a result seen now
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		rsp_t exp_r;
		bit   moved;
		if (arst_n) begin
			moved = 1'b0;
			if (done) begin
				moved = 1'b1;
				checked_cnt++;
				if (bound_q.size() == 0) begin
					err_cnt++;
					$display("%0t: result word with no search pending, got lower %0d upper %0d",
						$time, result.lower_out, result.upper_out);
				end else begin
					exp_r = bound_q.pop_front();
					if (result.lower_out !== exp_r.lower_out) begin
						err_cnt++;
						$display("%0t: lower_out mismatch, expected %0d actual %0d",
							$time, exp_r.lower_out, result.lower_out);
					end
					if (result.upper_out !== exp_r.upper_out) begin
						err_cnt++;
						$display("%0t: upper_out mismatch, expected %0d actual %0d",
							$time, exp_r.upper_out, result.upper_out);
					end
				end
			end
			if (cfg_we)
				mode_q = cfg_data;
			if (start && !busy) begin
				moved = 1'b1;
				if (cmd.opcode == OP_WRITE) begin
					write_cnt++;
					if (cmd.hint_index < HINTS)
						hint_tbl[cmd.hint_index] = cmd.hint_value;
				end else begin
					search_cnt++;
					bound_q.push_back(predict_bounds(cmd));
				end
			end
			// watchdog on a stuck handshake
			if (moved)
				stall_ctr = 0;
			else
				stall_ctr++;
			if (stall_ctr >= WATCHDOG) begin
				$display("%0t: no word moved for %0d cycles, %0d results outstanding",
					$time, WATCHDOG, bound_q.size());
				$display("tb: failure");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// word builders: fields the opcode ignores still get random values
	// ------------------------------------------------------------------------
	function automatic cmd_t write_word(logic [IDX_W-1:0] idx, logic [KEY_W-1:0] val);
		cmd_t c;
		c.opcode     = OP_WRITE;
		c.hint_index = idx;
		c.hint_value = val;
		c.key_head   = $urandom;
		c.slot_count = SLOT_W'($urandom);
		c.lower_in   = SLOT_W'($urandom);
		c.upper_in   = SLOT_W'($urandom);
		return c;
	endfunction

	function automatic cmd_t search_word(logic [KEY_W-1:0] key, logic [SLOT_W-1:0] cnt,
		logic [SLOT_W-1:0] lo, logic [SLOT_W-1:0] up);
		cmd_t c;
		c.opcode     = OP_SEARCH;
		c.hint_index = IDX_W'($urandom);
		c.hint_value = $urandom;
		c.key_head   = key;
		c.slot_count = cnt;
		c.lower_in   = lo;
		c.upper_in   = up;
		return c;
	endfunction

	// keys near the stored hints hit the interesting compare paths
	function automatic logic [KEY_W-1:0] pick_key();
		int unsigned      sel;
		logic [KEY_W-1:0] k;
		sel = $urandom_range(0, 9);
		k   = hint_tbl[$urandom_range(0, HINTS - 1)];
		if (sel < 4)
			return k;
		else if (sel < 6)
			return k + 1;
		else if (sel < 7)
			return k - 1;
		return $urandom;
	endfunction

	// mostly nodes big enough to narrow, some right at the threshold or below
	function automatic logic [SLOT_W-1:0] pick_count();
		int unsigned sel;
		sel = $urandom_range(0, 19);
		if (sel < 3)
			return SLOT_W'($urandom_range(0, 2 * HINTS));
		else if (sel == 3)
			return SLOT_W'(2 * HINTS + 1);
		else if (sel == 4)
			return {SLOT_W{1'b1}};
		return SLOT_W'($urandom_range(2 * HINTS + 1, 4095));
	endfunction

	// ------------------------------------------------------------------------
	// handshake tasks: inputs change only at the falling edge
	// ------------------------------------------------------------------------

	// hold the word until a rising edge sees busy low; start stays high on return
	// so back-to-back words leave no idle gap on start
	task automatic send_word(cmd_t c);
		@(negedge clk);
		start <= 1'b1;
		cmd   <= c;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic idle_cycles(int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	task automatic maybe_idle();
		if (idle_on && $urandom_range(0, 3) == 0)
			idle_cycles($urandom_range(1, 18));
	endtask

	// sender stands still until every pending search has answered,
	// then waits out a search that may still be running
	task automatic wait_results_done();
		@(negedge clk);
		start <= 1'b0;
		while (bound_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE)
			@(posedge clk);
	endtask

	// only called with the block idle
	task automatic set_hint_mode(logic [MODE_W-1:0] m);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= m;
		@(negedge clk);
		cfg_we   <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// after reset: scalar mode, table all zero
	task automatic test_reset_state();
		// key zero matches every hint, upper passes through
		send_word(search_word('0, 12'd4095, 12'd5, 12'd4000));
		// key above every hint, lower jumps to the top stride
		send_word(search_word('1, 12'd4095, 12'd0, 12'd4095));
		// threshold: 2*HINTS slots passes through, one more narrows
		send_word(search_word(32'd1, 12'(2 * HINTS), 12'd7, 12'd9));
		send_word(search_word(32'd1, 12'(2 * HINTS + 1), 12'd7, 12'd9));
		send_word(search_word(32'd1, 12'd0, 12'hfff, 12'hfff));
		wait_results_done();
	endtask

	// a few hints at the top of the table, with a duplicate run
	task automatic test_hint_lookup();
		send_word(write_word(4'd12, 32'd100));
		send_word(write_word(4'd13, 32'h8000_0000));
		send_word(write_word(4'd14, 32'h8000_0000));
		send_word(write_word(4'd15, 32'hffff_ffff));
		send_word(search_word(32'h8000_0000, 12'd4095, 12'd0, 12'd0));
		send_word(search_word(32'd50, 12'd2000, 12'd1, 12'd2));
		send_word(search_word(32'hffff_ffff, 12'd1234, 12'd3, 12'd4000));
		send_word(search_word(32'd100, 12'd3000, 12'd0, 12'hfff));
		wait_results_done();
	endtask

	// every mode code, including the unlisted one
	task automatic test_mode_codes();
		send_word(write_word(4'd15, 32'hffff_fffe));
		wait_results_done();
		set_hint_mode(MODE_VECTOR);
		// no hint reaches the first key: both bounds kept
		send_word(search_word(32'hffff_ffff, 12'd4095, 12'd11, 12'd22));
		send_word(search_word(32'd50, 12'd4095, 12'd11, 12'd22));
		wait_results_done();
		set_hint_mode(MODE_OFF);
		send_word(search_word(32'd50, 12'd4095, 12'd33, 12'd44));
		wait_results_done();
		set_hint_mode(MODE_UNLISTED);
		send_word(search_word(32'd50, 12'd4095, 12'd55, 12'd66));
		wait_results_done();
		set_hint_mode(MODE_SCALAR);
		send_word(search_word(32'hffff_ffff, 12'd4095, 12'd77, 12'd88));
		wait_results_done();
	endtask

	// one mode setting: load the table, then mostly searches with stray writes
	task automatic run_random_phase(logic [MODE_W-1:0] m, int n_search, bit gaps,
		int pause_at);
		logic [KEY_W-1:0] vals [$];
		bit               tight;
		int               i;
		set_hint_mode(m);
		idle_on = gaps;
		if ($urandom_range(0, 4) != 0) begin
			// sorted table; a tight value range makes runs of equal hints
			tight = $urandom_range(0, 1);
			vals.delete();
			repeat (HINTS)
				vals.push_back(tight ? KEY_W'($urandom_range(0, 40)) : KEY_W'($urandom));
			vals.sort();
			for (i = 0; i < HINTS; i++) begin
				send_word(write_word(IDX_W'(i), vals[i]));
				maybe_idle();
			end
		end else begin
			// unsorted noise on top of whatever is there
			repeat ($urandom_range(1, 6)) begin
				send_word(write_word(IDX_W'($urandom), $urandom));
				maybe_idle();
			end
		end
		for (i = 0; i < n_search; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_word(write_word(IDX_W'($urandom), pick_key()));
			else
				send_word(search_word(pick_key(), pick_count(),
					SLOT_W'($urandom), SLOT_W'($urandom)));
			maybe_idle();
			if (i == pause_at)
				wait_results_done();
		end
		wait_results_done();
	endtask

	task automatic test_random_traffic();
		run_random_phase(MODE_SCALAR,   60, 1'b1, -1);
		run_random_phase(MODE_VECTOR,   60, 1'b1, 30);
		run_random_phase(MODE_OFF,      40, 1'b1, -1);
		run_random_phase(MODE_UNLISTED, 40, 1'b0, -1);
		run_random_phase(MODE_VECTOR,   70, $urandom_range(0, 1), -1);
		// closing stretch: back-to-back words, no gaps
		run_random_phase(MODE_SCALAR,   80, 1'b0, -1);
	endtask

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		cmd         = '0;
		cfg_we      = 1'b0;
		cfg_data    = '0;
		err_cnt     = 0;
		write_cnt   = 0;
		search_cnt  = 0;
		narrow_cnt  = 0;
		checked_cnt = 0;
		stall_ctr   = 0;
		idle_on     = 1'b0;
		mode_q      = MODE_SCALAR;
		for (int i = 0; i < HINTS; i++)
			hint_tbl[i] = '0;
		repeat (8)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_state();
		test_hint_lookup();
		test_mode_codes();
		test_random_traffic();

		$display("covered %0d hint writes and %0d searches over all four mode codes",
			write_cnt, search_cnt);
		$display("%0d searches narrowed by hints, %0d result words checked",
			narrow_cnt, checked_cnt);
		if (err_cnt == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
